@@ hw/rtl/bal_pkg.sv @@
package bal_pkg;

	localparam int NUM_BINS_DEF   = 16;
	localparam int VALUE_BITS_DEF = 32;
	localparam int COUNT_BITS_DEF = 24;

	localparam logic [15:0] OFFSET_RESET = 16'd0;
	localparam logic [4:0]  BINS_RESET   = 5'd16;

	localparam logic CFG_OFFSET = 1'b0;
	localparam logic CFG_BINS   = 1'b1;

	typedef enum logic [2:0] {
		OP_CLEAR = 3'd0,
		OP_ACCUM = 3'd1,
		OP_FINAL = 3'd2,
		OP_WEDGE = 3'd3,
		OP_WVAL  = 3'd4,
		OP_EVAL  = 3'd5,
		OP_RVAL  = 3'd6
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_SAT   = 2'd2
	} status_t;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_SCAN = 8'b0000_0010,
		S_BRD  = 8'b0000_0100,
		S_VRD  = 8'b0000_1000,
		S_FRD  = 8'b0001_0000,
		S_DIV  = 8'b0010_0000,
		S_FIN  = 8'b0100_0000,
		S_RESP = 8'b1000_0000
	} state_t;

endpackage

@@ hw/rtl/binned_average_lookup.sv @@
// channel   direction  fields (low bit up)
// s_*       in         opcode[2:0] x_value[34:3] y_value[66:35] index[71:67]
// m_*       out        result_value[31:0] bin_index[35:32] status[37:36] zero[39:38]
// cfg_*     in         cfg_index 0 output_offset, 1 bins_in_use; cfg_wdata[15:0]
//
// One word in flight at a time; s_tready is high only when the sequencer is idle.
// Clear, write edge, write value and a bad opcode go straight to the response. Read value
// first reads the value memory. Accumulate and evaluate scan the bins, one edge memory
// read per step. Finalize visits every bin: an empty one is skipped, else its sum is
// divided by its count in the serial divider.
// Reset clears valid bits of sums/counts and bin values at once; edges stay undefined.
// A result waiting on m_tready does not block acceptance of the next word.
module binned_average_lookup #(
	parameter int NUM_BINS   = bal_pkg::NUM_BINS_DEF,
	parameter int VALUE_BITS = bal_pkg::VALUE_BITS_DEF,
	parameter int COUNT_BITS = bal_pkg::COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // opcode, x_value, y_value, index
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // result_value, bin_index, status, zero pad
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata
);

	localparam int SUM_BITS = VALUE_BITS + COUNT_BITS;
	localparam int SW       = SUM_BITS + COUNT_BITS;
	localparam int BIN_W    = $clog2(NUM_BINS);
	localparam int EA_W     = $clog2(NUM_BINS + 1);
	localparam int DC_W     = $clog2(SUM_BITS + 1);

	localparam logic signed [64:0] VMAX65 =
		{{(66 - VALUE_BITS){1'b0}}, {(VALUE_BITS - 1){1'b1}}};
	localparam logic signed [64:0] VMIN65 = ~VMAX65;
	localparam logic signed [64:0] RMAX65 = {34'd0, {31{1'b1}}};
	localparam logic signed [64:0] RMIN65 = ~RMAX65;
	localparam logic signed [SUM_BITS:0] QMAX =
		{{(COUNT_BITS + 2){1'b0}}, {(VALUE_BITS - 1){1'b1}}};
	localparam logic signed [SUM_BITS:0] QMIN = ~QMAX;
	localparam logic signed [SUM_BITS:0] SMAX = {2'b00, {(SUM_BITS - 1){1'b1}}};
	localparam logic signed [SUM_BITS:0] SMIN = ~SMAX;

	bal_pkg::state_t state_q;
	bal_pkg::opcode_t op_q;
	logic signed [31:0] x_q, y_q;
	logic [BIN_W-1:0] k_q;
	logic [15:0] offset_q;
	logic [4:0] bins_q;
	logic [NUM_BINS-1:0] svld_q, vvld_q;
	logic svld_rd_q, vvld_rd_q;
	logic [31:0] res_q;
	logic [3:0] bin_q;
	bal_pkg::status_t st_q;
	logic m_valid_q;
	logic [37:0] m_data_q;
	logic [SUM_BITS-1:0] dvd_q;
	logic [COUNT_BITS:0] rem_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic neg_q;
	logic [DC_W-1:0] dcnt_q;

	logic [2:0] in_opbits;
	logic signed [31:0] in_x, in_y;
	logic [4:0] in_idx;
	logic accept;
	logic wedge_ok, val_ok;
	logic [BIN_W-1:0] last_bin;

	logic edge_we;
	logic [EA_W-1:0] edge_waddr, edge_raddr;
	logic [VALUE_BITS-1:0] edge_wdata, edge_rdata;
	logic sum_we;
	logic [BIN_W-1:0] sum_waddr, sum_raddr;
	logic [SW-1:0] sum_wdata, sum_rdata;
	logic val_we;
	logic [BIN_W-1:0] val_waddr, val_raddr;
	logic [VALUE_BITS-1:0] val_wdata, val_rdata;

	logic signed [64:0] x65, e65, inx65, iny65, v65;
	logic [VALUE_BITS-1:0] inx_clamp, iny_clamp;
	logic [31:0] v_clamp;
	logic hit;
	logic [SW-1:0] sw;
	logic signed [SUM_BITS-1:0] s_cur;
	logic [COUNT_BITS-1:0] c_cur;
	logic c_full;
	logic signed [SUM_BITS:0] s_new, s_sat;
	logic s_ovf;
	logic [SUM_BITS-1:0] mag;
	logic [COUNT_BITS:0] rem_sh;
	logic rem_ge;
	logic signed [SUM_BITS:0] q_s;
	logic [VALUE_BITS-1:0] q_clamp;
	logic [VALUE_BITS-1:0] vv;
	logic fin_last;

	assign in_opbits = s_tdata[2:0];
	assign in_x      = s_tdata[34:3];
	assign in_y      = s_tdata[66:35];
	assign in_idx    = s_tdata[71:67];

	assign s_tready = (state_q == bal_pkg::S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, m_data_q};

	assign wedge_ok = (int'(in_idx) <= NUM_BINS);
	assign val_ok   = (int'(in_idx) < NUM_BINS);
	assign fin_last = (k_q == BIN_W'(NUM_BINS - 1));

	always_comb begin
		if (bins_q == 5'd0) begin
			last_bin = '0;
		end else if (int'(bins_q) > NUM_BINS) begin
			last_bin = BIN_W'(NUM_BINS - 1);
		end else begin
			last_bin = BIN_W'(bins_q - 5'd1);
		end
	end

	// saturate written edges and values to the storage width
	always_comb begin
		inx65 = 65'(in_x);
		iny65 = 65'(in_y);
		if (inx65 > VMAX65) inx_clamp = VALUE_BITS'(VMAX65);
		else if (inx65 < VMIN65) inx_clamp = VALUE_BITS'(VMIN65);
		else inx_clamp = VALUE_BITS'(inx65);
		if (iny65 > VMAX65) iny_clamp = VALUE_BITS'(VMAX65);
		else if (iny65 < VMIN65) iny_clamp = VALUE_BITS'(VMIN65);
		else iny_clamp = VALUE_BITS'(iny65);
	end

	assign x65 = 65'(x_q);
	assign e65 = 65'($signed(edge_rdata));
	assign hit = (x65 < e65) || (k_q == last_bin);

	assign sw     = svld_rd_q ? sum_rdata : '0;
	assign s_cur  = $signed(sw[SUM_BITS-1:0]);
	assign c_cur  = sw[SW-1:SUM_BITS];
	assign c_full = &c_cur;
	assign s_new  = {s_cur[SUM_BITS-1], s_cur} + (SUM_BITS + 1)'(y_q);
	assign s_ovf  = (s_new[SUM_BITS] != s_new[SUM_BITS-1]);
	assign s_sat  = s_ovf ? (s_new[SUM_BITS] ? SMIN : SMAX) : s_new;
	assign mag    = s_cur[SUM_BITS-1] ? SUM_BITS'(-s_cur) : SUM_BITS'(s_cur);

	assign rem_sh = {rem_q[COUNT_BITS-1:0], dvd_q[SUM_BITS-1]};
	assign rem_ge = (rem_sh >= {1'b0, cnt_q});

	always_comb begin
		q_s = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});
		if (q_s > QMAX) q_clamp = VALUE_BITS'(QMAX);
		else if (q_s < QMIN) q_clamp = VALUE_BITS'(QMIN);
		else q_clamp = VALUE_BITS'(q_s);
	end

	always_comb begin
		vv  = vvld_rd_q ? val_rdata : '0;
		v65 = 65'($signed(vv));
		if (op_q == bal_pkg::OP_EVAL) begin
			v65 = v65 + 65'(offset_q);
		end
		if (v65 > RMAX65) v_clamp = 32'(RMAX65);
		else if (v65 < RMIN65) v_clamp = 32'(RMIN65);
		else v_clamp = 32'(v65);
	end

	always_comb begin
		edge_we    = accept && (in_opbits == bal_pkg::OP_WEDGE) && wedge_ok;
		edge_waddr = EA_W'(in_idx);
		edge_wdata = inx_clamp;
		edge_raddr = (state_q == bal_pkg::S_SCAN) ? EA_W'(k_q) + EA_W'(2) : EA_W'(1);

		sum_we    = (state_q == bal_pkg::S_BRD) && (op_q == bal_pkg::OP_ACCUM) && !c_full;
		sum_waddr = k_q;
		sum_wdata = {c_cur + COUNT_BITS'(1), SUM_BITS'(s_sat)};
		if (state_q == bal_pkg::S_IDLE) begin
			sum_raddr = '0;
		end else if (state_q inside {bal_pkg::S_FRD, bal_pkg::S_FIN}) begin
			sum_raddr = k_q + BIN_W'(1);
		end else begin
			sum_raddr = k_q;
		end

		val_we    = 1'b0;
		val_waddr = k_q;
		val_wdata = '0;
		if (accept && (in_opbits == bal_pkg::OP_WVAL) && val_ok) begin
			val_we    = 1'b1;
			val_waddr = BIN_W'(in_idx);
			val_wdata = iny_clamp;
		end else if (state_q == bal_pkg::S_FRD && c_cur == '0) begin
			val_we = 1'b1;
		end else if (state_q == bal_pkg::S_FIN) begin
			val_we    = 1'b1;
			val_wdata = q_clamp;
		end
		val_raddr = (state_q == bal_pkg::S_IDLE) ? BIN_W'(in_idx) : k_q;
	end

	bal_ram #(.WIDTH(VALUE_BITS), .DEPTH(NUM_BINS + 1)) u_edge (
		.clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
		.raddr(edge_raddr), .rdata(edge_rdata)
	);

	bal_ram #(.WIDTH(SW), .DEPTH(NUM_BINS)) u_sum (
		.clk(clk), .we(sum_we), .waddr(sum_waddr), .wdata(sum_wdata),
		.raddr(sum_raddr), .rdata(sum_rdata)
	);

	bal_ram #(.WIDTH(VALUE_BITS), .DEPTH(NUM_BINS)) u_val (
		.clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
		.raddr(val_raddr), .rdata(val_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= bal_pkg::S_IDLE;
			offset_q  <= bal_pkg::OFFSET_RESET;
			bins_q    <= bal_pkg::BINS_RESET;
			svld_q    <= '0;
			vvld_q    <= '0;
			svld_rd_q <= 1'b0;
			vvld_rd_q <= 1'b0;
			m_valid_q <= 1'b0;
			k_q       <= '0;
			dcnt_q    <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == bal_pkg::CFG_OFFSET) offset_q <= cfg_wdata;
				else bins_q <= cfg_wdata[4:0];
			end

			svld_rd_q <= (int'(sum_raddr) < NUM_BINS) ? svld_q[sum_raddr] : 1'b0;
			vvld_rd_q <= (int'(val_raddr) < NUM_BINS) ? vvld_q[val_raddr] : 1'b0;
			if (sum_we) svld_q[sum_waddr] <= 1'b1;
			if (val_we) vvld_q[val_waddr] <= 1'b1;

			if (m_valid_q && m_tready && state_q != bal_pkg::S_RESP) m_valid_q <= 1'b0;

			case (state_q)
				bal_pkg::S_IDLE: begin
					if (accept) begin
						op_q  <= bal_pkg::opcode_t'(in_opbits);
						x_q   <= in_x;
						y_q   <= in_y;
						k_q   <= '0;
						res_q <= '0;
						bin_q <= '0;
						case (in_opbits)
							bal_pkg::OP_CLEAR: begin
								svld_q  <= '0;
								st_q    <= bal_pkg::ST_OK;
								state_q <= bal_pkg::S_RESP;
							end
							bal_pkg::OP_ACCUM, bal_pkg::OP_EVAL: begin
								st_q    <= bal_pkg::ST_OK;
								state_q <= bal_pkg::S_SCAN;
							end
							bal_pkg::OP_FINAL: begin
								st_q    <= bal_pkg::ST_OK;
								state_q <= bal_pkg::S_FRD;
							end
							bal_pkg::OP_WEDGE: begin
								st_q    <= wedge_ok ? bal_pkg::ST_OK : bal_pkg::ST_RANGE;
								state_q <= bal_pkg::S_RESP;
							end
							bal_pkg::OP_WVAL: begin
								st_q    <= val_ok ? bal_pkg::ST_OK : bal_pkg::ST_RANGE;
								state_q <= bal_pkg::S_RESP;
							end
							bal_pkg::OP_RVAL: begin
								st_q    <= val_ok ? bal_pkg::ST_OK : bal_pkg::ST_RANGE;
								state_q <= val_ok ? bal_pkg::S_VRD : bal_pkg::S_RESP;
							end
							default: begin
								st_q    <= bal_pkg::ST_RANGE;
								state_q <= bal_pkg::S_RESP;
							end
						endcase
					end
				end
				bal_pkg::S_SCAN: begin
					if (hit) state_q <= bal_pkg::S_BRD;
					else k_q <= k_q + BIN_W'(1);
				end
				bal_pkg::S_BRD: begin
					bin_q <= 4'(k_q);
					if (op_q == bal_pkg::OP_ACCUM) begin
						if (c_full || s_ovf) st_q <= bal_pkg::ST_SAT;
					end else begin
						res_q <= v_clamp;
					end
					state_q <= bal_pkg::S_RESP;
				end
				bal_pkg::S_VRD: begin
					res_q   <= v_clamp;
					state_q <= bal_pkg::S_RESP;
				end
				bal_pkg::S_FRD: begin
					if (c_cur == '0) begin
						if (fin_last) state_q <= bal_pkg::S_RESP;
						k_q <= k_q + BIN_W'(1);
					end else begin
						dvd_q   <= mag;
						rem_q   <= '0;
						cnt_q   <= c_cur;
						neg_q   <= s_cur[SUM_BITS-1];
						dcnt_q  <= DC_W'(SUM_BITS);
						state_q <= bal_pkg::S_DIV;
					end
				end
				bal_pkg::S_DIV: begin
					rem_q  <= rem_ge ? rem_sh - {1'b0, cnt_q} : rem_sh;
					dvd_q  <= {dvd_q[SUM_BITS-2:0], rem_ge};
					dcnt_q <= dcnt_q - DC_W'(1);
					if (dcnt_q == DC_W'(1)) state_q <= bal_pkg::S_FIN;
				end
				bal_pkg::S_FIN: begin
					k_q     <= k_q + BIN_W'(1);
					state_q <= fin_last ? bal_pkg::S_RESP : bal_pkg::S_FRD;
				end
				bal_pkg::S_RESP: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						m_data_q  <= {st_q, bin_q, res_q};
						state_q   <= bal_pkg::S_IDLE;
					end
				end
				default: state_q <= bal_pkg::S_IDLE;
			endcase
		end
	end

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("word accepted while another is in flight");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bal_pkg::S_DIV) |-> (dcnt_q != '0))
		else $error("divider running with zero step count");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bal_pkg::S_SCAN) |-> (k_q <= last_bin))
		else $error("bin scan past last active bin");

endmodule

@@ hw/rtl/bal_ram.sv @@
module bal_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
